// ----- hw/rtl/bilinear_wrap_sampler_macros.svh -----
// ----------------------------------------------------------------------------
// bilinear wrap sampler assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef BILINEAR_WRAP_SAMPLER_MACROS_SVH
`define BILINEAR_WRAP_SAMPLER_MACROS_SVH

// same-cycle implication
`define BWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bws assertion failed");

// implication checked a fixed number of cycles later
`define BWS_ASSERT_LAT(label, ante, lat, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error("bws latency assertion failed");

`endif

// ----- hw/rtl/bws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_pkg
// shared types and constants of the bilinear wrap sampler
// ----------------------------------------------------------------------------
package bws_pkg;

  // texel and field widths
  localparam int TEXEL_W    = 8;
  localparam int COORD_W    = 16;
  localparam int RESULT_W   = 16;
  localparam int OUT_FRAC   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int REG_RESET  = 256;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  // operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // input word
  typedef struct packed {
    op_t                  op;
    logic [7:0]           write_x;
    logic [7:0]           write_y;
    logic [TEXEL_W-1:0]   texel_value;
    logic [COORD_W-1:0]   s_pos;
    logic [COORD_W-1:0]   t_pos;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [RESULT_W-1:0]  sample_value;
    logic                 out_of_range;
  } out_word_t;

endpackage

// ----- hw/rtl/bws_texel_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_texel_ram
// one copy of the texel store: one write port, one registered read port
// ----------------------------------------------------------------------------
module bws_texel_ram #(
  parameter int ADDR_W = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [bws_pkg::TEXEL_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [bws_pkg::TEXEL_W-1:0] rd_data
);

  logic [bws_pkg::TEXEL_W-1:0] mem_r [(1 << ADDR_W)];
  logic [bws_pkg::TEXEL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bilinear_wrap_sampler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_wrap_sampler
// bilinear heightmap sampler with wrapping right and lower neighbors
// ----------------------------------------------------------------------------
// usage
// - input channel: a word is taken on a rising edge with start high and busy
//   low. busy stays low, so one word can enter every cycle. op = write stores
//   texel_value at (write_x, write_y); op = sample interpolates at (s_pos,
//   t_pos), fixed point with FRAC_BITS fraction bits.
// - result channel: each sample gives one word on out_word, marked by
//   out_valid for one cycle. writes give no word. the receiver cannot stall,
//   so results leave at the rate samples enter.
// - pipeline: a result passes these registers after its word is taken:
//   decode, texel read and weights, products, sum into the output register.
//   throughput is one word per cycle, set by four copies of the texel store,
//   one per neighbor, each read once and all written in parallel on a write.
// - a sample taken in the cycle after a write already sees that texel.
// - config: cfg_we writes map_width (index 0) or map_height (index 1) at once.
// - reset (rst_n low, synchronous) empties the pipeline and sets both sizes
//   to 256 bounded by the store size; the texel store itself is not cleared.
// ----------------------------------------------------------------------------
`include "bilinear_wrap_sampler_macros.svh"

module bilinear_wrap_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bws_pkg::in_word_t                in_word,
  output logic                             out_valid,
  output bws_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bws_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IW      = bws_pkg::COORD_W - FRAC_BITS;
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int AW      = XW + YW;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int FW      = FRAC_BITS + 1;
  localparam int WTW     = 2 * FRAC_BITS + 1;
  localparam int PW      = bws_pkg::TEXEL_W + 2 * FRAC_BITS;
  localparam int SHIFT   = 2 * FRAC_BITS - bws_pkg::OUT_FRAC;
  localparam int W_RST   = (bws_pkg::REG_RESET > MAX_WIDTH) ? MAX_WIDTH : bws_pkg::REG_RESET;
  localparam int H_RST   = (bws_pkg::REG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : bws_pkg::REG_RESET;
  localparam int PIPE_LAT = 4;
  localparam logic [FW-1:0] FRAC_ONE = FW'(1 << FRAC_BITS);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [WW-1:0] map_width_r, map_width_nxt;
  logic [HW-1:0] map_height_r, map_height_nxt;
  logic [31:0]   cfg_val;

  assign cfg_val = 32'(cfg_wdata);

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    if (cfg_we) begin
      case (cfg_idx)
        bws_pkg::REG_MAP_WIDTH: begin
          if (cfg_val == 32'd0) map_width_nxt = WW'(1);
          else if (cfg_val > 32'(MAX_WIDTH)) map_width_nxt = WW'(MAX_WIDTH);
          else map_width_nxt = WW'(cfg_val);
        end
        bws_pkg::REG_MAP_HEIGHT: begin
          if (cfg_val == 32'd0) map_height_nxt = HW'(1);
          else if (cfg_val > 32'(MAX_HEIGHT)) map_height_nxt = HW'(MAX_HEIGHT);
          else map_height_nxt = HW'(cfg_val);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= WW'(W_RST);
      map_height_r <= HW'(H_RST);
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: decode, range check, neighbor addresses
  // --------------------------------------------------------------------------
  logic            accept;
  logic [IW-1:0]   ui, vi;
  logic [31:0]     ui_inc, vi_inc;
  logic [XW-1:0]   ux, un;
  logic [YW-1:0]   vy, vn;
  logic            coord_oor;
  logic            wr_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ui     = in_word.s_pos[bws_pkg::COORD_W-1:FRAC_BITS];
  assign vi     = in_word.t_pos[bws_pkg::COORD_W-1:FRAC_BITS];
  assign ui_inc = 32'(ui) + 32'd1;
  assign vi_inc = 32'(vi) + 32'd1;
  assign ux     = XW'(ui);
  assign vy     = YW'(vi);

  // wrap right and lower neighbors at the map edge
  assign un = (ui_inc == 32'(map_width_r))  ? '0 : XW'(ui_inc);
  assign vn = (vi_inc == 32'(map_height_r)) ? '0 : YW'(vi_inc);

  assign coord_oor = (32'(ui) >= 32'(map_width_r)) || (32'(vi) >= 32'(map_height_r));
  assign wr_ok     = (32'(in_word.write_x) < 32'(MAX_WIDTH)) &&
                     (32'(in_word.write_y) < 32'(MAX_HEIGHT));

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_wr_r, s1_wr_nxt;
  logic                         s1_oor_r, s1_oor_nxt;
  logic [AW-1:0]                s1_a00_r, s1_a00_nxt;
  logic [AW-1:0]                s1_a10_r, s1_a10_nxt;
  logic [AW-1:0]                s1_a01_r, s1_a01_nxt;
  logic [AW-1:0]                s1_a11_r, s1_a11_nxt;
  logic [FRAC_BITS-1:0]         s1_fu_r, s1_fu_nxt;
  logic [FRAC_BITS-1:0]         s1_fv_r, s1_fv_nxt;
  logic [AW-1:0]                s1_waddr_r, s1_waddr_nxt;
  logic [bws_pkg::TEXEL_W-1:0]  s1_wdata_r, s1_wdata_nxt;

  always_comb begin
    s1_valid_nxt = accept && (in_word.op == bws_pkg::OP_SAMPLE);
    s1_wr_nxt    = accept && (in_word.op == bws_pkg::OP_WRITE) && wr_ok;
    s1_oor_nxt   = coord_oor;
    s1_a00_nxt   = {vy, ux};
    s1_a10_nxt   = {vy, un};
    s1_a01_nxt   = {vn, ux};
    s1_a11_nxt   = {vn, un};
    s1_fu_nxt    = in_word.s_pos[FRAC_BITS-1:0];
    s1_fv_nxt    = in_word.t_pos[FRAC_BITS-1:0];
    s1_waddr_nxt = {YW'(in_word.write_y), XW'(in_word.write_x)};
    s1_wdata_nxt = in_word.texel_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_wr_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_wr_r    <= s1_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor_r   <= s1_oor_nxt;
    s1_a00_r   <= s1_a00_nxt;
    s1_a10_r   <= s1_a10_nxt;
    s1_a01_r   <= s1_a01_nxt;
    s1_a11_r   <= s1_a11_nxt;
    s1_fu_r    <= s1_fu_nxt;
    s1_fv_r    <= s1_fv_nxt;
    s1_waddr_r <= s1_waddr_nxt;
    s1_wdata_r <= s1_wdata_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 2: texel reads from four store copies, weight products
  // --------------------------------------------------------------------------
  logic [bws_pkg::TEXEL_W-1:0] t00, t10, t01, t11;

  bws_texel_ram #(.ADDR_W(AW)) u_ram00 (
    .clk     (clk),
    .wr_en   (s1_wr_r),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_wdata_r),
    .rd_addr (s1_a00_r),
    .rd_data (t00)
  );

  bws_texel_ram #(.ADDR_W(AW)) u_ram10 (
    .clk     (clk),
    .wr_en   (s1_wr_r),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_wdata_r),
    .rd_addr (s1_a10_r),
    .rd_data (t10)
  );

  bws_texel_ram #(.ADDR_W(AW)) u_ram01 (
    .clk     (clk),
    .wr_en   (s1_wr_r),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_wdata_r),
    .rd_addr (s1_a01_r),
    .rd_data (t01)
  );

  bws_texel_ram #(.ADDR_W(AW)) u_ram11 (
    .clk     (clk),
    .wr_en   (s1_wr_r),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_wdata_r),
    .rd_addr (s1_a11_r),
    .rd_data (t11)
  );

  logic [FW-1:0]   fu_e, fv_e, fu_c, fv_c;
  logic [2*FW-1:0] w00_full, w10_full, w01_full, w11_full;

  assign fu_e = FW'(s1_fu_r);
  assign fv_e = FW'(s1_fv_r);
  assign fu_c = FRAC_ONE - fu_e;
  assign fv_c = FRAC_ONE - fv_e;

  assign w00_full = fu_c * fv_c;
  assign w10_full = fu_e * fv_c;
  assign w01_full = fu_c * fv_e;
  assign w11_full = fu_e * fv_e;

  logic           s2_valid_r, s2_valid_nxt;
  logic           s2_oor_r, s2_oor_nxt;
  logic [WTW-1:0] s2_w00_r, s2_w00_nxt;
  logic [WTW-1:0] s2_w10_r, s2_w10_nxt;
  logic [WTW-1:0] s2_w01_r, s2_w01_nxt;
  logic [WTW-1:0] s2_w11_r, s2_w11_nxt;

  always_comb begin
    s2_valid_nxt = s1_valid_r;
    s2_oor_nxt   = s1_oor_r;
    s2_w00_nxt   = w00_full[WTW-1:0];
    s2_w10_nxt   = w10_full[WTW-1:0];
    s2_w01_nxt   = w01_full[WTW-1:0];
    s2_w11_nxt   = w11_full[WTW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_oor_r <= s2_oor_nxt;
    s2_w00_r <= s2_w00_nxt;
    s2_w10_r <= s2_w10_nxt;
    s2_w01_r <= s2_w01_nxt;
    s2_w11_r <= s2_w11_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 3: texel times weight
  // --------------------------------------------------------------------------
  logic [bws_pkg::TEXEL_W+WTW-1:0] p00_full, p10_full, p01_full, p11_full;

  assign p00_full = (bws_pkg::TEXEL_W+WTW)'(t00) * (bws_pkg::TEXEL_W+WTW)'(s2_w00_r);
  assign p10_full = (bws_pkg::TEXEL_W+WTW)'(t10) * (bws_pkg::TEXEL_W+WTW)'(s2_w10_r);
  assign p01_full = (bws_pkg::TEXEL_W+WTW)'(t01) * (bws_pkg::TEXEL_W+WTW)'(s2_w01_r);
  assign p11_full = (bws_pkg::TEXEL_W+WTW)'(t11) * (bws_pkg::TEXEL_W+WTW)'(s2_w11_r);

  logic          s3_valid_r, s3_valid_nxt;
  logic          s3_oor_r, s3_oor_nxt;
  logic [PW-1:0] s3_p00_r, s3_p00_nxt;
  logic [PW-1:0] s3_p10_r, s3_p10_nxt;
  logic [PW-1:0] s3_p01_r, s3_p01_nxt;
  logic [PW-1:0] s3_p11_r, s3_p11_nxt;

  always_comb begin
    s3_valid_nxt = s2_valid_r;
    s3_oor_nxt   = s2_oor_r;
    s3_p00_nxt   = p00_full[PW-1:0];
    s3_p10_nxt   = p10_full[PW-1:0];
    s3_p01_nxt   = p01_full[PW-1:0];
    s3_p11_nxt   = p11_full[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s3_oor_r <= s3_oor_nxt;
    s3_p00_r <= s3_p00_nxt;
    s3_p10_r <= s3_p10_nxt;
    s3_p01_r <= s3_p01_nxt;
    s3_p11_r <= s3_p11_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 4: sum, truncate to 8 fraction bits (zero when out of range), output register
  // --------------------------------------------------------------------------
  logic [PW+1:0] sum_full;

  assign sum_full = (PW+2)'(s3_p00_r) + (PW+2)'(s3_p10_r) +
                    (PW+2)'(s3_p01_r) + (PW+2)'(s3_p11_r);

  logic               out_valid_r, out_valid_nxt;
  bws_pkg::out_word_t out_word_r, out_word_nxt;

  always_comb begin
    out_valid_nxt = s3_valid_r;
    if (s3_oor_r) begin
      out_word_nxt.sample_value = '0;
      out_word_nxt.out_of_range = 1'b1;
    end else begin
      out_word_nxt.sample_value = sum_full[SHIFT +: bws_pkg::RESULT_W];
      out_word_nxt.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic take_sample, take_write, sizes_ok;

  assign take_sample = accept && (in_word.op == bws_pkg::OP_SAMPLE);
  assign take_write  = accept && (in_word.op == bws_pkg::OP_WRITE);
  assign sizes_ok    = (map_width_r != '0) && (map_height_r != '0) &&
                       (32'(map_width_r) <= 32'(MAX_WIDTH)) &&
                       (32'(map_height_r) <= 32'(MAX_HEIGHT));

  `BWS_ASSERT_LAT(a_sample_gives_word, take_sample, PIPE_LAT, out_valid)
  `BWS_ASSERT_LAT(a_write_gives_none, take_write, PIPE_LAT, !out_valid)
  `BWS_ASSERT_IMPL(a_oor_zero, out_valid && out_word.out_of_range, out_word.sample_value == '0)
  `BWS_ASSERT_IMPL(a_sizes_legal, 1'b1, sizes_ok)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bilinear wrap sampler: texel writes and samples
// are queued per map size setting, driven with random gaps, and every result
// word is checked against an in-bench bilinear predictor of the heightmap
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAP_MAX     = 256;
  localparam int          FRAC_W      = 8;
  localparam int unsigned FRAC_UNIT   = 1 << FRAC_W;
  localparam int          PIPE_SLACK  = 8;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 128;
  localparam int          ERR_SHOWN   = 40;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  bws_pkg::in_word_t              in_word   = '0;
  logic                           out_valid;
  bws_pkg::out_word_t             out_word;
  logic                           cfg_we    = 1'b0;
  logic [bws_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [bws_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // map sizes as the block sees them, and the texels it holds
  int unsigned map_w = MAP_MAX;
  int unsigned map_h = MAP_MAX;
  logic [bws_pkg::TEXEL_W-1:0] height_map [0:MAP_MAX*MAP_MAX-1];
  // texels already queued for writing, so samples only read loaded texels
  bit texel_loaded [0:MAP_MAX*MAP_MAX-1];

  bws_pkg::in_word_t  word_queue[$];
  bws_pkg::out_word_t pending_samples[$];
  bit        word_taken   = 1'b0;
  int        send_idle_pct = 0;
  int        stall_cycles  = 0;
  int        fail_count    = 0;
  int        items_queued  = 0;

  int unsigned width_plan  [10] = '{256, 2, 1, 511, 3, 256, 0, 16, 5, 300};
  int unsigned height_plan [10] = '{256, 3, 1, 4, 511, 1, 256, 0, 7, 2};

  bilinear_wrap_sampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // size register semantics: zero acts as one, large values saturate
  function automatic int unsigned fit_size(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAP_MAX) return MAP_MAX;
    return v;
  endfunction

  function automatic bws_pkg::in_word_t random_word();
    logic [63:0] bits_r;
    bits_r = {$urandom, $urandom};
    return bws_pkg::in_word_t'(bits_r[$bits(bws_pkg::in_word_t)-1:0]);
  endfunction

  // updates the heightmap on a write; on a sample returns 1 with the result
  function automatic bit bilinear_predict(input bws_pkg::in_word_t w,
                                          output bws_pkg::out_word_t res);
    int unsigned ui, vi, un, vn, fu, fv;
    int unsigned c00, c10, c11, c01, acc;
    res = '0;
    if (w.op == bws_pkg::OP_WRITE) begin
      height_map[{w.write_y, w.write_x}] = w.texel_value;
      return 1'b0;
    end
    ui = w.s_pos >> FRAC_W;
    vi = w.t_pos >> FRAC_W;
    fu = w.s_pos & (FRAC_UNIT - 1);
    fv = w.t_pos & (FRAC_UNIT - 1);
    if (ui >= map_w || vi >= map_h) begin
      res.out_of_range = 1'b1;
      return 1'b1;
    end
    // right and lower neighbors wrap at the map edge
    un = (ui + 1 == map_w) ? 0 : ui + 1;
    vn = (vi + 1 == map_h) ? 0 : vi + 1;
    c00 = height_map[16'(vi * MAP_MAX + ui)];
    c10 = height_map[16'(vi * MAP_MAX + un)];
    c11 = height_map[16'(vn * MAP_MAX + un)];
    c01 = height_map[16'(vn * MAP_MAX + ui)];
    acc = c00 * ((FRAC_UNIT - fu) * (FRAC_UNIT - fv))
        + c10 * (fu * (FRAC_UNIT - fv))
        + c11 * (fu * fv)
        + c01 * ((FRAC_UNIT - fu) * fv);
    res.sample_value = 16'(acc >> (2 * FRAC_W - bws_pkg::OUT_FRAC));
    return 1'b1;
  endfunction

  // stimulus helpers
  task automatic queue_write(input int unsigned x, input int unsigned y,
                             input int unsigned v);
    bws_pkg::in_word_t w;
    w = random_word();
    w.op          = bws_pkg::OP_WRITE;
    w.write_x     = 8'(x);
    w.write_y     = 8'(y);
    w.texel_value = 8'(v);
    texel_loaded[16'(y * MAP_MAX + x)] = 1'b1;
    word_queue.push_back(w);
    items_queued++;
  endtask

  task automatic load_texel(input int unsigned x, input int unsigned y);
    if (!texel_loaded[16'(y * MAP_MAX + x)]) queue_write(x, y, $urandom_range(255));
  endtask

  // a sample preceded by writes of any neighbor not yet loaded
  task automatic queue_sample(input logic [bws_pkg::COORD_W-1:0] s,
                              input logic [bws_pkg::COORD_W-1:0] t);
    bws_pkg::in_word_t w;
    int unsigned ui, vi, un, vn;
    ui = s >> FRAC_W;
    vi = t >> FRAC_W;
    if (ui < map_w && vi < map_h) begin
      un = (ui + 1 == map_w) ? 0 : ui + 1;
      vn = (vi + 1 == map_h) ? 0 : vi + 1;
      load_texel(ui, vi);
      load_texel(un, vi);
      load_texel(un, vn);
      load_texel(ui, vn);
    end
    w = random_word();
    w.op    = bws_pkg::OP_SAMPLE;
    w.s_pos = s;
    w.t_pos = t;
    word_queue.push_back(w);
    items_queued++;
  endtask

  task automatic queue_random_item();
    int unsigned pick;
    logic [bws_pkg::COORD_W-1:0] s, t;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(3) != 0)
        queue_write($urandom_range(map_w - 1), $urandom_range(map_h - 1),
                    $urandom_range(255));
      else
        queue_write($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end else if (pick < 38) begin
      // full-range coordinates, mostly beyond a small map
      queue_sample(16'($urandom), 16'($urandom));
    end else begin
      s = 16'(($urandom_range(map_w - 1) << FRAC_W) | $urandom_range(255));
      t = 16'(($urandom_range(map_h - 1) << FRAC_W) | $urandom_range(255));
      queue_sample(s, t);
    end
  endtask

  task automatic write_reg(input logic [bws_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[bws_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= bws_pkg::CFG_DATA_W'($urandom);
    @(negedge clk);
  endtask

  // sender holds off until every queued word has gone and all results are in
  task automatic wait_results();
    while (word_queue.size() != 0 || start || pending_samples.size() != 0)
      @(negedge clk);
  endtask

  // writes leave no result, so allow the pipeline to empty as well
  task automatic wait_idle();
    wait_results();
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // driver: a word stays on the port until taken
  always @(negedge clk) begin : drive_words
    logic              nxt_start;
    bws_pkg::in_word_t nxt_word;
    nxt_start = start;
    nxt_word  = in_word;
    if (!start || word_taken) begin
      if (rst_n && word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_start = 1'b1;
        nxt_word  = word_queue.pop_front();
      end else begin
        nxt_start = 1'b0;
        nxt_word  = random_word();
      end
    end
    start   <= nxt_start;
    in_word <= nxt_word;
  end

  // monitor: check results, track config, predict each taken word
  always @(posedge clk) begin : watch_ports
    bws_pkg::out_word_t want;
    bws_pkg::out_word_t got;
    if (!rst_n) begin
      word_taken = 1'b0;
    end else begin
      if (out_valid) begin
        got = out_word;
        if (pending_samples.size() == 0) begin
          if (fail_count < ERR_SHOWN)
            $display("%0t: unexpected result word, expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = pending_samples.pop_front();
          if (got.sample_value !== want.sample_value) begin
            if (fail_count < ERR_SHOWN)
              $display("%0t: sample_value mismatch, expected %h actual %h",
                       $time, want.sample_value, got.sample_value);
            fail_count++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            if (fail_count < ERR_SHOWN)
              $display("%0t: out_of_range mismatch, expected %b actual %b",
                       $time, want.out_of_range, got.out_of_range);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == bws_pkg::REG_MAP_WIDTH) map_w = fit_size(32'(cfg_wdata));
        else if (cfg_idx == bws_pkg::REG_MAP_HEIGHT) map_h = fit_size(32'(cfg_wdata));
      end
      word_taken = start && !busy;
      if (word_taken && bilinear_predict(in_word, want)) pending_samples.push_back(want);
      if (word_taken || out_valid || cfg_we) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog on cycles with no traffic
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin : run_phases
    int unsigned w_set, h_set;
    int          goal;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners at full map: both neighbors wrap, extreme texel values
    send_idle_pct = 22;
    queue_write(255, 255, 255);
    queue_write(0, 255, 0);
    queue_write(255, 0, 255);
    queue_write(0, 0, 0);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'hFF00, 16'h0000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h00FF, 16'h00FF);
    queue_sample(16'h0080, 16'h0080);
    // sample right after a write to the texel it reads
    queue_write(0, 0, 255);
    queue_sample(16'h0000, 16'h0000);
    wait_idle();

    // zero width acts as one, oversize height saturates
    write_reg(bws_pkg::REG_MAP_WIDTH, 0);
    write_reg(bws_pkg::REG_MAP_HEIGHT, 511);
    queue_sample(16'h0080, 16'hFF80);
    queue_sample(16'h0100, 16'h0000);
    queue_sample(16'hFFFF, 16'h0000);
    wait_idle();

    write_reg(bws_pkg::REG_MAP_WIDTH, 256);
    write_reg(bws_pkg::REG_MAP_HEIGHT, 1);
    queue_sample(16'h1234, 16'h00FF);
    queue_sample(16'h0000, 16'h0100);
    queue_sample(16'hFFFF, 16'hFFFF);
    wait_idle();

    // random phases over a spread of map sizes, neighbor loads included
    for (int p = 0; p < PHASES; p++) begin
      if (p < 10) begin
        w_set = width_plan[4'(p)];
        h_set = height_plan[4'(p)];
      end else begin
        w_set = $urandom_range(511);
        h_set = $urandom_range(511);
      end
      write_reg(bws_pkg::REG_MAP_WIDTH, w_set);
      write_reg(bws_pkg::REG_MAP_HEIGHT, h_set);
      send_idle_pct = (p < 4) ? 22 : (p < 8) ? 77 : 0;
      goal = items_queued + PHASE_ITEMS / 2;
      while (items_queued < goal) queue_random_item();
      wait_results();
      goal = items_queued + PHASE_ITEMS / 2;
      while (items_queued < goal) queue_random_item();
      wait_idle();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
